// File: hdl/etpq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the event time priority queue
// no dependencies

package etpq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int TIME_W              = 32;
    localparam int JOB_W               = 16;
    localparam int KIND_W              = 3;
    localparam int COUNT_OUT_W         = 5;
    localparam int STATUS_W            = 2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] ev_time;
        logic [JOB_W-1:0]  job_id;
        logic [KIND_W-1:0] event_kind;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

// File: hdl/etpq_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for command and result beats
// depends on etpq_pkg

interface etpq_in_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [etpq_pkg::TIME_W-1:0]  ev_time;
    logic [etpq_pkg::JOB_W-1:0]   job_id;
    logic [etpq_pkg::KIND_W-1:0]  event_kind;

    modport source (output valid, operation, ev_time, job_id, event_kind, input ready);
    modport sink   (input valid, operation, ev_time, job_id, event_kind, output ready);
endinterface

interface etpq_out_if;
    logic                            valid;
    logic                            ready;
    logic [etpq_pkg::TIME_W-1:0]     head_time;
    logic [etpq_pkg::JOB_W-1:0]      head_job;
    logic [etpq_pkg::KIND_W-1:0]     head_kind;
    logic                            head_valid;
    logic [etpq_pkg::COUNT_OUT_W-1:0] entry_count;
    logic [etpq_pkg::STATUS_W-1:0]   status;

    modport source (output valid, head_time, head_job, head_kind, head_valid, entry_count,
                    status, input ready);
    modport sink   (input valid, head_time, head_job, head_kind, head_valid, entry_count,
                    status, output ready);
endinterface

// File: hdl/etpq_cell.sv
`timescale 1ns / 1ps
// one slot of the sorted chain: holds an entry, compares against the pushed time
// and shifts toward the tail on insert or toward the head on pop; depends on etpq_pkg

module etpq_cell (
    input  logic                i_clk,
    input  etpq_pkg::t_cell_ctl i_ctl,
    input  etpq_pkg::t_entry    i_new_entry,
    input  logic                i_is_head,
    input  logic                i_occupied,
    input  logic                i_prev_ge,
    input  etpq_pkg::t_entry    i_prev_entry,
    input  etpq_pkg::t_entry    i_next_entry,
    output logic                o_ge,
    output etpq_pkg::t_entry    o_entry
);

    etpq_pkg::t_entry r_entry;
    etpq_pkg::t_entry n_entry;
    logic             later;

    // head only yields to a strictly later time, others to a not-earlier one
    assign later = i_is_head ? (r_entry.ev_time >  i_new_entry.ev_time)
                             : (r_entry.ev_time >= i_new_entry.ev_time);
    assign o_ge    = !i_occupied || later;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push) begin
            if (i_prev_ge) begin
                n_entry = i_prev_entry;
            end else if (o_ge) begin
                n_entry = i_new_entry;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: hdl/event_time_priority_queue_core.sv
`timescale 1ns / 1ps
// top level of the event time priority queue: chain of etpq_cell slots, fill count and
// result register; depends on etpq_pkg, etpq_if and etpq_cell
// a result beat is registered and valid in the cycle after its command beat is accepted
// throughput: one push or pop per cycle; all slots of the chain update on the same edge
// a new command waits only while a result beat is held back by the sink
// reset: synchronous active low, clears fill count and result valid; slots are not cleared

module event_time_priority_queue_core #(
    parameter int QUEUE_DEPTH = etpq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    etpq_in_if.sink             i_cmd,
    etpq_out_if.source          o_res
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]                r_count;
    logic [CNT_W-1:0]                n_count;
    logic                            r_out_valid;
    logic [etpq_pkg::STATUS_W-1:0]   r_status;
    logic [etpq_pkg::STATUS_W-1:0]   n_status;

    logic                            accept;
    logic                            is_full;
    logic                            q_empty;
    etpq_pkg::t_cell_ctl             ctl;
    etpq_pkg::t_entry                new_entry;

    etpq_pkg::t_entry                cell_entry [QUEUE_DEPTH];
    logic                            cell_ge    [QUEUE_DEPTH];

    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign is_full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign q_empty     = (r_count == '0);

    assign new_entry = {i_cmd.ev_time, i_cmd.job_id, i_cmd.event_kind};

    assign ctl = '{push: accept && (i_cmd.operation == etpq_pkg::OP_PUSH) && !is_full,
                   pop:  accept && (i_cmd.operation == etpq_pkg::OP_POP) && !q_empty};

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            etpq_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl),
                .i_new_entry  (new_entry),
                .i_is_head    (gi == 0),
                .i_occupied   (r_count > CNT_W'(gi)),
                .i_prev_ge    ((gi == 0) ? 1'b0 : cell_ge[(gi == 0) ? 0 : gi - 1]),
                .i_prev_entry (cell_entry[(gi == 0) ? 0 : gi - 1]),
                .i_next_entry (cell_entry[(gi == QUEUE_DEPTH - 1) ? gi : gi + 1]),
                .o_ge         (cell_ge[gi]),
                .o_entry      (cell_entry[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_status = r_status;
        if (accept) begin
            n_status = etpq_pkg::STATUS_OK;
            case (i_cmd.operation)
                etpq_pkg::OP_PUSH: begin
                    if (is_full) begin
                        n_status = etpq_pkg::STATUS_FULL;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                etpq_pkg::OP_POP: begin
                    if (q_empty) begin
                        n_status = etpq_pkg::STATUS_EMPTY;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.head_valid  = !q_empty;
    assign o_res.head_time   = q_empty ? '0 : cell_entry[0].ev_time;
    assign o_res.head_job    = q_empty ? '0 : cell_entry[0].job_id;
    assign o_res.head_kind   = q_empty ? '0 : cell_entry[0].event_kind;
    assign o_res.entry_count = etpq_pkg::COUNT_OUT_W'(r_count);
    assign o_res.status      = r_status;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count beyond depth");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |-> !i_cmd.ready)
        else $error("command taken while result beat stalled");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.pop |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("pop did not decrement count");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd.operation == etpq_pkg::OP_PUSH) && is_full)
        |=> (is_full && (r_status == etpq_pkg::STATUS_FULL)))
        else $error("push into full queue not dropped");
`endif

endmodule
